// ----- rtl/core/ghtab_pkg.sv -----
`default_nettype none

package ghtab_pkg;

  // Request kinds as they arrive on the input channel.
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_LOOKUP = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;

  // Result status codes.
  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_BAD  = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  // Handle layout.
  localparam int TYPE_LSB = 28;
  localparam int GEN_LSB  = 16;
  localparam int GEN_W    = 12;
  localparam int HIDX_W   = 16;

  localparam logic [GEN_W-1:0] GEN_INIT = 12'h001;
  localparam logic [GEN_W-1:0] GEN_MAX  = 12'hFFF;

  // Operation after classification by the front end.
  typedef enum logic [1:0] {
    OP_INSERT,
    OP_LOOKUP,
    OP_REMOVE,
    OP_REJECT
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [1:0]        typ;
    logic [GEN_W-1:0]  gen;
    logic [HIDX_W-1:0] index;
    logic [31:0]       obj;
  } cmd_t;

  // Queue head as seen by the back end.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmdq_head_t;

endpackage

`default_nettype wire

// ----- rtl/core/ghtab_ram.sv -----
`default_nettype none

module ghtab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                           wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- rtl/core/ghtab_front.sv -----
`default_nettype none

module ghtab_front #(
  parameter int SLOTS = 256
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic [1:0]              kind_i,
  input  wire logic [1:0]              obj_type_i,
  input  wire logic [31:0]             object_ref_i,
  input  wire logic [31:0]             handle_i,
  input  wire logic [1:0]              expected_type_i,
  output ghtab_pkg::cmdq_head_t        head_o,
  input  wire logic                    pop_i
);

  import ghtab_pkg::*;

  logic [3:0]        h_type;
  logic [GEN_W-1:0]  h_gen;
  logic [HIDX_W-1:0] h_ip1;
  logic              hdl_ok;
  logic              type_ok;
  cmd_t              cmd_new;

  cmd_t       ent_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;

  assign h_type = handle_i[TYPE_LSB +: 4];
  assign h_gen  = handle_i[GEN_LSB +: GEN_W];
  assign h_ip1  = handle_i[HIDX_W-1:0];

  // Everything about a handle that does not need the table is settled here.
  assign hdl_ok = (h_ip1 != '0) && (h_gen != '0) && (h_type >= 4'd1) && (h_type <= 4'd3)
                  && (17'(h_ip1) <= 17'(SLOTS));
  assign type_ok = (expected_type_i == 2'd0) || ({2'b00, expected_type_i} == h_type);

  always_comb begin
    cmd_new.gen   = h_gen;
    cmd_new.index = h_ip1 - 16'd1;
    cmd_new.obj   = object_ref_i;
    cmd_new.typ   = h_type[1:0];
    cmd_new.op    = OP_REJECT;
    case (kind_i)
      KIND_INSERT: begin
        cmd_new.typ = obj_type_i;
        if (obj_type_i != 2'd0) cmd_new.op = OP_INSERT;
      end
      KIND_LOOKUP: begin
        if (hdl_ok && type_ok) cmd_new.op = OP_LOOKUP;
      end
      KIND_REMOVE: begin
        if (hdl_ok) cmd_new.op = OP_REMOVE;
      end
      default: cmd_new.op = OP_REJECT;
    endcase
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= cmd_new;
    end
  end

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.cmd   = ent_q[rd_ptr_q];

endmodule

`default_nettype wire

// ----- rtl/core/ghtab_back.sv -----
`default_nettype none

module ghtab_back #(
  parameter int SLOTS       = 256,
  parameter int OBJECT_BITS = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ghtab_pkg::cmdq_head_t head_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [1:0]              status_o,
  output logic [31:0]             handle_out_o,
  output logic [31:0]             object_out_o
);

  import ghtab_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int GRP_N = (SLOTS + 15) / 16;
  localparam int GRP_W = (GRP_N > 1) ? $clog2(GRP_N) : 1;
  localparam int PAD_N = GRP_N * 16;
  localparam int TO_W  = OBJECT_BITS + 2;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_FIND = 2'd1;
  localparam logic [1:0] S_PICK = 2'd2;
  localparam logic [1:0] S_EXEC = 2'd3;

  logic [1:0] state_q, state_d;
  cmd_t       cur_q;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic       found_q, found_d;

  logic [SLOTS-1:0] valid_q, retired_q, genset_q;

  logic [PAD_N-1:0]         busy;
  logic [GRP_N-1:0]         grp_any_d, grp_any_q;
  logic [GRP_N-1:0][3:0]    grp_low_d, grp_low_q;
  logic [GRP_W-1:0]         pick_grp;
  logic                     pick_any;
  logic [IDX_W-1:0]         pick_idx;

  logic [IDX_W-1:0] raddr;
  logic             to_we;
  logic [TO_W-1:0]  to_wdata, to_rdata;
  logic             gen_we;
  logic [GEN_W-1:0] gen_wdata, gen_rdata, gen_eff;
  logic             hit;
  logic             start;

  logic             out_valid_q;
  logic [1:0]       status_q, status_d;
  logic [31:0]      hout_q, hout_d, oout_q, oout_d;

  assign start = (state_q == S_IDLE) && head_i.valid && !out_valid_q;
  assign pop_o = start;

  // First stage of the free-slot search: lowest free slot in each group of 16.
  always_comb begin
    busy = '1;
    busy[SLOTS-1:0] = valid_q | retired_q;
    for (int g = 0; g < GRP_N; g++) begin
      grp_any_d[g] = 1'b0;
      grp_low_d[g] = 4'd0;
      for (int b = 15; b >= 0; b--) begin
        if (!busy[g*16 + b]) begin
          grp_any_d[g] = 1'b1;
          grp_low_d[g] = 4'(b);
        end
      end
    end
  end

  // Second stage: lowest group that has a free slot.
  always_comb begin
    pick_any = 1'b0;
    pick_grp = '0;
    for (int g = GRP_N - 1; g >= 0; g--) begin
      if (grp_any_q[g]) begin
        pick_any = 1'b1;
        pick_grp = GRP_W'(g);
      end
    end
    pick_idx = IDX_W'({pick_grp, grp_low_q[pick_grp]});
  end

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    found_d = found_q;
    raddr   = idx_q;
    case (state_q)
      S_IDLE: begin
        raddr = head_i.cmd.index[IDX_W-1:0];
        if (start) begin
          idx_d   = head_i.cmd.index[IDX_W-1:0];
          state_d = (head_i.cmd.op == OP_INSERT) ? S_FIND : S_EXEC;
        end
      end
      S_FIND: state_d = S_PICK;
      S_PICK: begin
        raddr   = pick_idx;
        idx_d   = pick_idx;
        found_d = pick_any;
        state_d = S_EXEC;
      end
      S_EXEC: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  ghtab_ram #(
    .WIDTH (TO_W),
    .DEPTH (SLOTS)
  ) u_type_obj_ram (
    .clk_i   (clk_i),
    .we_i    (to_we),
    .waddr_i (idx_q),
    .wdata_i (to_wdata),
    .raddr_i (raddr),
    .rdata_o (to_rdata)
  );

  ghtab_ram #(
    .WIDTH (GEN_W),
    .DEPTH (SLOTS)
  ) u_gen_ram (
    .clk_i   (clk_i),
    .we_i    (gen_we),
    .waddr_i (idx_q),
    .wdata_i (gen_wdata),
    .raddr_i (raddr),
    .rdata_o (gen_rdata)
  );

  // A slot's generation lives in memory only once a remove has raised it.
  assign gen_eff = genset_q[idx_q] ? gen_rdata : GEN_INIT;
  assign hit = valid_q[idx_q] && !retired_q[idx_q] && (to_rdata[1:0] == cur_q.typ)
               && (gen_eff == cur_q.gen);

  always_comb begin
    to_we     = 1'b0;
    to_wdata  = {OBJECT_BITS'(cur_q.obj), cur_q.typ};
    gen_we    = 1'b0;
    gen_wdata = gen_eff + 12'd1;
    status_d  = STATUS_BAD;
    hout_d    = '0;
    oout_d    = '0;
    if (state_q == S_EXEC) begin
      case (cur_q.op)
        OP_INSERT: begin
          if (found_q) begin
            to_we    = 1'b1;
            status_d = STATUS_OK;
            hout_d   = {2'b00, cur_q.typ, gen_eff, 16'(idx_q) + 16'd1};
          end else begin
            status_d = STATUS_FULL;
          end
        end
        OP_LOOKUP, OP_REMOVE: begin
          if (hit) begin
            status_d = STATUS_OK;
            oout_d   = 32'(to_rdata[TO_W-1:2]);
            gen_we   = (cur_q.op == OP_REMOVE) && (gen_eff != GEN_MAX);
          end
        end
        default: status_d = STATUS_BAD;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      retired_q   <= '0;
      genset_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == S_EXEC) begin
        out_valid_q <= 1'b1;
        if (cur_q.op == OP_INSERT && found_q) begin
          valid_q[idx_q] <= 1'b1;
        end
        if (cur_q.op == OP_REMOVE && hit) begin
          valid_q[idx_q] <= 1'b0;
          if (gen_eff == GEN_MAX) begin
            retired_q[idx_q] <= 1'b1;
          end else begin
            genset_q[idx_q] <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    found_q   <= found_d;
    grp_any_q <= grp_any_d;
    grp_low_q <= grp_low_d;
    if (start) begin
      cur_q <= head_i.cmd;
    end
    if (state_q == S_EXEC) begin
      status_q <= status_d;
      hout_q   <= hout_d;
      oout_q   <= oout_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign handle_out_o = hout_q;
  assign object_out_o = oout_q;

endmodule

`default_nettype wire

// ----- rtl/core/generational_handle_table.sv -----
// Channel   Direction  tuser           tdata
// s_axis    in         kind            obj_type, object_ref, handle, expected_type
// m_axis    out        status          handle_out, object_out
//
// In the back end, lookup and remove read memory in S_IDLE, then check and
// write back in S_EXEC; insert passes S_FIND and S_PICK first, since the
// free-slot search runs over two registered stages before slot memory is read.
// A two-item queue lets requests be taken while the back end works or its
// result waits; the back end starts an item once the output register is empty.
// Reset clears all slot marks at once; no clearing pass is needed.
`default_nettype none

module generational_handle_table #(
  parameter int SLOTS       = 256,
  parameter int OBJECT_BITS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [1:0]  s_axis_tuser,  // kind
  // obj_type [1:0], object_ref [33:2], handle [65:34], expected_type [67:66]
  input  wire logic [71:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [1:0]       m_axis_tuser,  // status
  output logic [63:0]      m_axis_tdata   // handle_out [31:0], object_out [63:32]
);

  import ghtab_pkg::*;

  cmdq_head_t head;
  logic       pop;

  ghtab_front #(
    .SLOTS (SLOTS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .kind_i          (s_axis_tuser),
    .obj_type_i      (s_axis_tdata[1:0]),
    .object_ref_i    (s_axis_tdata[33:2]),
    .handle_i        (s_axis_tdata[65:34]),
    .expected_type_i (s_axis_tdata[67:66]),
    .head_o          (head),
    .pop_i           (pop)
  );

  ghtab_back #(
    .SLOTS       (SLOTS),
    .OBJECT_BITS (OBJECT_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .status_o     (m_axis_tuser),
    .handle_out_o (m_axis_tdata[31:0]),
    .object_out_o (m_axis_tdata[63:32])
  );

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
`default_nettype none

module tb;
  import ghtab_pkg::*;

  localparam int SLOTS       = 256;
  localparam int OBJ_BITS    = 32;
  localparam int RANDOM_ITEMS = 1350;
  localparam int CYCLE_LIMIT = 1_500_000;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [1:0] TYPE_ANY    = 2'd0;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  obj_type;
    logic [31:0] object_ref;
    logic [31:0] handle;
    logic [1:0]  expected_type;
  } table_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] handle_out;
    logic [31:0] object_out;
  } table_res_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  obj_type;
    logic [31:0] object_ref;
    logic [31:0] handle;
    logic [1:0]  expected_type;
    logic        typed;
    logic [1:0]  status;
    logic [31:0] handle_out;
    logic [31:0] object_out;
  } directed_row_t;

  localparam int DIRECTED_ROWS = 25;
  // Rows with typed set carry their result; the others take the predicted one.
  localparam directed_row_t DIRECTED_TABLE [DIRECTED_ROWS] = '{
    '{KIND_INSERT, 2'd1, 32'h0000_0000, 32'h0,         TYPE_ANY, 1'b1, STATUS_OK,
      32'h1001_0001, 32'h0000_0000},
    '{KIND_INSERT, 2'd3, 32'hFFFF_FFFF, 32'h0,         TYPE_ANY, 1'b1, STATUS_OK,
      32'h3001_0002, 32'h0000_0000},
    '{KIND_INSERT, 2'd2, 32'hA5A5_5A5A, 32'h0,         TYPE_ANY, 1'b1, STATUS_OK,
      32'h2001_0003, 32'h0000_0000},
    '{KIND_LOOKUP, 2'd0, 32'h0,         32'h1001_0001, TYPE_ANY, 1'b1, STATUS_OK,
      32'h0,         32'h0000_0000},
    '{KIND_LOOKUP, 2'd0, 32'h0,         32'h3001_0002, 2'd3,     1'b1, STATUS_OK,
      32'h0,         32'hFFFF_FFFF},
    '{KIND_LOOKUP, 2'd0, 32'h0,         32'h3001_0002, 2'd1,     1'b1, STATUS_BAD,
      32'h0,         32'h0},
    '{KIND_LOOKUP, 2'd0, 32'h0,         32'h2001_0002, TYPE_ANY, 1'b1, STATUS_BAD,
      32'h0,         32'h0},
    '{KIND_LOOKUP, 2'd0, 32'h0,         32'h3002_0002, TYPE_ANY, 1'b1, STATUS_BAD,
      32'h0,         32'h0},
    '{KIND_LOOKUP, 2'd0, 32'h0,         32'h0001_0001, TYPE_ANY, 1'b1, STATUS_BAD,
      32'h0,         32'h0},
    '{KIND_LOOKUP, 2'd0, 32'h0,         32'h4001_0001, TYPE_ANY, 1'b1, STATUS_BAD,
      32'h0,         32'h0},
    '{KIND_LOOKUP, 2'd0, 32'h0,         32'hF001_0001, TYPE_ANY, 1'b1, STATUS_BAD,
      32'h0,         32'h0},
    '{KIND_LOOKUP, 2'd0, 32'h0,         32'h1000_0001, TYPE_ANY, 1'b1, STATUS_BAD,
      32'h0,         32'h0},
    '{KIND_LOOKUP, 2'd0, 32'h0,         32'h1001_0000, TYPE_ANY, 1'b1, STATUS_BAD,
      32'h0,         32'h0},
    '{KIND_LOOKUP, 2'd0, 32'h0,         32'h1001_0101, TYPE_ANY, 1'b1, STATUS_BAD,
      32'h0,         32'h0},
    '{KIND_LOOKUP, 2'd0, 32'h0,         32'h1001_FFFF, TYPE_ANY, 1'b1, STATUS_BAD,
      32'h0,         32'h0},
    '{KIND_LOOKUP, 2'd0, 32'h0,         32'h1001_0100, TYPE_ANY, 1'b1, STATUS_BAD,
      32'h0,         32'h0},
    '{KIND_INSERT, 2'd0, 32'h1111_1111, 32'h0,         TYPE_ANY, 1'b1, STATUS_BAD,
      32'h0,         32'h0},
    '{KIND_UNUSED, 2'd1, 32'h2222_2222, 32'h1001_0001, TYPE_ANY, 1'b1, STATUS_BAD,
      32'h0,         32'h0},
    '{KIND_REMOVE, 2'd0, 32'h0,         32'h3001_0002, 2'd1,     1'b1, STATUS_OK,
      32'h0,         32'hFFFF_FFFF},
    '{KIND_REMOVE, 2'd0, 32'h0,         32'h3001_0002, TYPE_ANY, 1'b1, STATUS_BAD,
      32'h0,         32'h0},
    '{KIND_LOOKUP, 2'd0, 32'h0,         32'h3001_0002, TYPE_ANY, 1'b1, STATUS_BAD,
      32'h0,         32'h0},
    '{KIND_INSERT, 2'd3, 32'h1234_5678, 32'h0,         TYPE_ANY, 1'b0, STATUS_OK,
      32'h0,         32'h0},
    '{KIND_REMOVE, 2'd0, 32'h0,         32'h1001_0001, TYPE_ANY, 1'b1, STATUS_OK,
      32'h0,         32'h0000_0000},
    '{KIND_REMOVE, 2'd0, 32'h0,         32'h2001_0003, TYPE_ANY, 1'b1, STATUS_OK,
      32'h0,         32'hA5A5_5A5A},
    '{KIND_REMOVE, 2'd0, 32'h0,         32'h3002_0002, TYPE_ANY, 1'b0, STATUS_OK,
      32'h0,         32'h0}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [1:0]  s_axis_tuser = '0;   // kind
  // obj_type [1:0], object_ref [33:2], handle [65:34], expected_type [67:66]
  logic [71:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [1:0]  m_axis_tuser;       // status
  logic [63:0] m_axis_tdata;       // handle_out [31:0], object_out [63:32]

  generational_handle_table #(
    .SLOTS       (SLOTS),
    .OBJECT_BITS (OBJ_BITS)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Shadow copy of the slot table.
  logic             tbl_valid   [SLOTS];
  logic             tbl_retired [SLOTS];
  logic [1:0]       tbl_type    [SLOTS];
  logic [GEN_W-1:0] tbl_gen     [SLOTS];
  logic [31:0]      tbl_obj     [SLOTS];

  table_res_t  expected_replies [$];
  logic [31:0] live_handles [$];
  logic [31:0] dead_handles [$];
  int          errors = 0;
  int          cycle_count = 0;
  bit          source_quiet = 1'b0;
  bit          sink_quiet = 1'b0;
  table_res_t  got_res;
  table_res_t  want_res;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[generational_handle_table] ERROR");
      $finish;
    end
  end

  // Idle stretches toggle now and then so that some runs go back to back.
  function automatic int draw_wait(inout bit quiet);
    if ($urandom_range(0, 39) == 0) quiet = !quiet;
    return quiet ? 0 : $urandom_range(0, 14);
  endfunction

  // Returns the slot a handle names, or -1 when the handle does not pass.
  function automatic int resolve_handle(logic [31:0] h, logic [1:0] filter);
    logic [3:0]        t;
    logic [GEN_W-1:0]  g;
    logic [HIDX_W-1:0] ip1;
    int                i;
    t   = h[TYPE_LSB +: 4];
    g   = h[GEN_LSB +: GEN_W];
    ip1 = h[HIDX_W-1:0];
    if (ip1 == 0 || g == 0 || t < 4'd1 || t > 4'd3) return -1;
    if (filter != TYPE_ANY && t != {2'b00, filter}) return -1;
    if (ip1 > SLOTS) return -1;
    i = int'(ip1) - 1;
    if (!tbl_valid[i] || tbl_retired[i]) return -1;
    if (tbl_type[i] != t[1:0] || tbl_gen[i] != g) return -1;
    return i;
  endfunction

  function automatic table_res_t apply_request(table_req_t rq);
    table_res_t res;
    int         slot;
    res.status     = STATUS_BAD;
    res.handle_out = '0;
    res.object_out = '0;
    slot = -1;
    case (rq.kind)
      KIND_INSERT: begin
        if (rq.obj_type != TYPE_ANY) begin
          res.status = STATUS_FULL;
          for (int i = 0; i < SLOTS; i++) begin
            if (slot < 0 && !tbl_valid[i] && !tbl_retired[i]) slot = i;
          end
          if (slot >= 0) begin
            tbl_valid[slot] = 1'b1;
            tbl_type[slot]  = rq.obj_type;
            tbl_obj[slot]   = rq.object_ref;
            res.status      = STATUS_OK;
            res.handle_out  = {2'b00, rq.obj_type, tbl_gen[slot], HIDX_W'(slot + 1)};
          end
        end
      end
      KIND_LOOKUP: begin
        slot = resolve_handle(rq.handle, rq.expected_type);
        if (slot >= 0) begin
          res.status     = STATUS_OK;
          res.object_out = tbl_obj[slot];
        end
      end
      KIND_REMOVE: begin
        slot = resolve_handle(rq.handle, TYPE_ANY);
        if (slot >= 0) begin
          res.status      = STATUS_OK;
          res.object_out  = tbl_obj[slot];
          tbl_valid[slot] = 1'b0;
          if (tbl_gen[slot] == GEN_MAX) tbl_retired[slot] = 1'b1;
          else tbl_gen[slot] = tbl_gen[slot] + 1'b1;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Mostly handles that are alive, some stale ones, some with one bit flipped.
  function automatic logic [31:0] pick_handle();
    int roll;
    roll = $urandom_range(0, 99);
    if (live_handles.size() > 0 && roll < 80)
      return live_handles[$urandom_range(0, live_handles.size() - 1)];
    if (dead_handles.size() > 0 && roll < 88)
      return dead_handles[$urandom_range(0, dead_handles.size() - 1)];
    if (live_handles.size() > 0 && roll < 96)
      return live_handles[$urandom_range(0, live_handles.size() - 1)]
             ^ (32'h1 << $urandom_range(0, 31));
    return $urandom;
  endfunction

  task automatic send_request(input table_req_t rq, input bit typed,
                              input table_res_t typed_res, output table_res_t pred);
    int gap;
    int hit;
    gap = draw_wait(source_quiet);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= rq.kind;
    s_axis_tdata  <= {4'b0000, rq.expected_type, rq.handle, rq.object_ref, rq.obj_type};
    do @(posedge clk_i); while (!s_axis_tready);
    pred = apply_request(rq);
    expected_replies.insert(expected_replies.size(), typed ? typed_res : pred);
    if (rq.kind == KIND_INSERT && pred.status == STATUS_OK)
      live_handles.insert(live_handles.size(), pred.handle_out);
    if (rq.kind == KIND_REMOVE && pred.status == STATUS_OK) begin
      hit = -1;
      foreach (live_handles[k]) if (live_handles[k] == rq.handle) hit = k;
      if (hit >= 0) live_handles.delete(hit);
      dead_handles.insert(dead_handles.size(), rq.handle);
      if (dead_handles.size() > 32) void'(dead_handles.pop_front());
    end
  endtask

  // Result side: a random stall before each item, then wait for it.
  initial begin
    int stall;
    forever begin
      stall = draw_wait(sink_quiet);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_res.status     = m_axis_tuser;
      got_res.handle_out = m_axis_tdata[31:0];
      got_res.object_out = m_axis_tdata[63:32];
      if (expected_replies.size() == 0) begin
        errors++;
        $display("%0t: unexpected item: status %0d handle_out %h object_out %h",
                 $time, got_res.status, got_res.handle_out, got_res.object_out);
      end else begin
        want_res = expected_replies.pop_front();
        if (got_res !== want_res) begin
          errors++;
          $display("%0t: mismatch: status exp %0d got %0d, handle_out exp %h got %h, %s %h got %h",
                   $time, want_res.status, got_res.status, want_res.handle_out,
                   got_res.handle_out, "object_out exp", want_res.object_out,
                   got_res.object_out);
        end
      end
    end
  end

  initial begin
    table_req_t    rq;
    table_res_t    typed_res;
    table_res_t    res;
    directed_row_t row;
    bit            filling;
    int            full_seen;
    int            drain_floor;
    int            roll;

    for (int i = 0; i < SLOTS; i++) begin
      tbl_valid[i]   = 1'b0;
      tbl_retired[i] = 1'b0;
      tbl_type[i]    = '0;
      tbl_gen[i]     = GEN_INIT;
      tbl_obj[i]     = '0;
    end
    rst_ni <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int n = 0; n < DIRECTED_ROWS; n++) begin
      row                  = DIRECTED_TABLE[n];
      rq.kind              = row.kind;
      rq.obj_type          = row.obj_type;
      rq.object_ref        = row.object_ref;
      rq.handle            = row.handle;
      rq.expected_type     = row.expected_type;
      typed_res.status     = row.status;
      typed_res.handle_out = row.handle_out;
      typed_res.object_out = row.object_out;
      send_request(rq, row.typed, typed_res, res);
    end

    // Alternate between filling the table up to full and draining it.
    filling     = 1'b1;
    full_seen   = 0;
    drain_floor = $urandom_range(0, 16);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      roll             = $urandom_range(0, 99);
      rq.obj_type      = $urandom_range(1, 3);
      rq.object_ref    = $urandom;
      rq.handle        = $urandom;
      rq.expected_type = $urandom_range(0, 3);
      if (roll < 5) begin
        rq.kind     = $urandom_range(0, 3);
        rq.obj_type = $urandom_range(0, 3);
      end else if (roll < (filling ? 80 : 15)) begin
        rq.kind = KIND_INSERT;
      end else if (roll < (filling ? 95 : 30)) begin
        rq.kind   = KIND_LOOKUP;
        rq.handle = pick_handle();
        if ($urandom_range(0, 1) == 1) rq.expected_type = rq.handle[TYPE_LSB +: 2];
      end else begin
        rq.kind   = KIND_REMOVE;
        rq.handle = pick_handle();
      end
      send_request(rq, 1'b0, '0, res);
      if (rq.kind == KIND_INSERT && res.status == STATUS_FULL) full_seen++;
      if (filling && full_seen >= 3) begin
        filling = 1'b0;
      end else if (!filling && live_handles.size() <= drain_floor) begin
        filling     = 1'b1;
        full_seen   = 0;
        drain_floor = $urandom_range(0, 16);
      end
    end
    s_axis_tvalid <= 1'b0;

    while (expected_replies.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (errors == 0) begin
      $display("[generational_handle_table] OK");
    end else begin
      $display("[generational_handle_table] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
